FILE: rtl/accel_double_tap_detector_unit_defines.svh
// assertion macros used by the checker of the double tap detector
`ifndef ACCEL_DOUBLE_TAP_DETECTOR_UNIT_DEFINES_SVH
`define ACCEL_DOUBLE_TAP_DETECTOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ADTD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define ADTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/adtd_pkg.sv
package adtd_pkg;

	localparam int RING_DEPTH_DEF = 10;
	localparam int ACCEL_W = 14;
	localparam int COUNT_W = 16;
	localparam int WARMUP_W = 6;
	localparam int STABLE_W = 8;
	localparam int TAP_W = 10;
	localparam int WINDOW_W = 5;
	localparam int TICKS_W = 6;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [ACCEL_W-1:0] ENTRY_RESET = 14'd1000;
	localparam logic [WARMUP_W-1:0] WARMUP_RESET = 6'd50;
	localparam logic [STABLE_W-1:0] STABLE_RESET = 8'd5;
	localparam logic [TAP_W-1:0] TAP_LOW_RESET = 10'd10;
	localparam logic [TAP_W-1:0] TAP_HIGH_RESET = 10'd50;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd10;
	localparam logic [TICKS_W-1:0] TICKS_MAX = 6'd63;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_WARMUP   = 3'd0,
		CFG_STABLE   = 3'd1,
		CFG_TAP_LOW  = 3'd2,
		CFG_TAP_HIGH = 3'd3,
		CFG_WINDOW   = 3'd4
	} cfg_index_t;

	// one ring slot of each of the four rings
	typedef struct packed {
		logic [ACCEL_W-1:0] base;
		logic [ACCEL_W-1:0] x;
		logic [ACCEL_W-1:0] y;
		logic [ACCEL_W-1:0] z;
	} ring_entry_t;

	typedef struct packed {
		logic shift;
		logic load_xyz;
		logic load_base;
		logic copy_base;
	} cell_ctl_t;

endpackage

FILE: rtl/accel_double_tap_detector_unit.sv
// accelerometer double tap detector
// s_* carries one sample per transfer (x, y, z in signed milli-g), m_* returns
// one result per sample: tap count, tap flag, stable flag and armed flag.
// cfg_* writes the five registers; cfg_ready is always high, write only while idle.
// a warm-up sample goes from its transfer straight to loading the output
// register; a detection sample passes through the ring and compare steps first:
// the ring slots sit in a row of cells that rotates once around, one slot per
// cycle, while the head slot feeds the four window sums; then the stability and
// deviation compare, the tap decision and ring copy, and the load of the output
// register follow in that order.
// one sample is worked on at a time, s_tready is high only while idle, so a new
// transfer waits until the previous sample has loaded its result.
// the result sits in an output register, so a new sample is taken while the
// previous result still waits; a stalled m_tready holds the result and only
// the finish of the following sample waits for it.
// reset sets all ring slots to 1000, clears counters, the stored previous sums
// and tap state and loads the register defaults.
module accel_double_tap_detector_unit #(
	parameter int RING_DEPTH = adtd_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// accel_x [13:0], accel_y [27:14], accel_z [41:28], zero [47:42]
	input  logic [adtd_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// double_tap_count [15:0], tap_detected [16], board_stable [17],
	// first_tap_armed [18], zero [23:19]
	output logic [adtd_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [adtd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = adtd_pkg::ACCEL_W;
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int SUM_W = AW + $clog2(RING_DEPTH);
	localparam int ABS_W = SUM_W + 1;
	localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SUM    = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	state_t state_q;

	logic [adtd_pkg::WARMUP_W-1:0] cfg_warmup_q;
	logic [adtd_pkg::STABLE_W-1:0] cfg_stable_q;
	logic [adtd_pkg::TAP_W-1:0] cfg_tap_low_q;
	logic [adtd_pkg::TAP_W-1:0] cfg_tap_high_q;
	logic [adtd_pkg::WINDOW_W-1:0] cfg_window_q;

	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] cnt_q;
	logic [adtd_pkg::WARMUP_W-1:0] warm_cnt_q;
	logic signed [SUM_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [SUM_W-1:0] acc_b_q, acc_x_q, acc_y_q, acc_z_q;
	logic [AW-1:0] z_q;
	logic [ABS_W-1:0] dev_q;
	logic [ABS_W-1:0] gap_q;
	logic armed_q, countdown_q, detected_q, stable_q;
	logic [adtd_pkg::TICKS_W-1:0] ticks_q;
	logic [adtd_pkg::COUNT_W-1:0] total_q;
	logic out_valid_q;
	logic [adtd_pkg::M_TDATA_W-1:0] out_data_q;

	logic in_fire, warm, out_load;
	logic [AW-1:0] in_x, in_y, in_z, wr_z;
	adtd_pkg::cell_ctl_t ctl;
	adtd_pkg::ring_entry_t entries [RING_DEPTH];

	logic signed [SUM_W-1:0] z_scaled;
	logic [ABS_W-1:0] lim, low_lim, high_lim, dev;
	logic stable_now, band;

	logic dec_armed, dec_countdown, dec_detected;
	logic [ABS_W-1:0] dec_gap;
	logic [adtd_pkg::COUNT_W-1:0] dec_total;
	logic [adtd_pkg::TICKS_W-1:0] dec_ticks;

	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
		return (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ABS_W-1:0] abs_diff(input logic signed [SUM_W-1:0] a,
			input logic signed [SUM_W-1:0] b);
		logic signed [ABS_W-1:0] d;
		d = ABS_W'(a) - ABS_W'(b);
		return d[ABS_W-1] ? ABS_W'(-d) : ABS_W'(d);
	endfunction

	assign in_x = s_tdata[AW-1:0];
	assign in_y = s_tdata[2*AW-1:AW];
	assign in_z = s_tdata[3*AW-1:2*AW];

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire = s_tvalid && s_tready;
	assign warm = (warm_cnt_q < cfg_warmup_q);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || m_tready);

	// compare stage
	assign z_scaled = SUM_W'($signed(z_q)) * SUM_W'(RING_DEPTH);
	assign dev = abs_diff(z_scaled, acc_b_q);
	assign lim = ABS_W'(cfg_stable_q) * ABS_W'(RING_DEPTH);
	assign stable_now = (abs_diff(prev_z_q, acc_z_q) < lim)
		&& (abs_diff(prev_x_q, acc_x_q) < lim)
		&& (abs_diff(prev_y_q, acc_y_q) < lim);

	// decision stage
	assign low_lim = ABS_W'(cfg_tap_low_q) * ABS_W'(RING_DEPTH);
	assign high_lim = ABS_W'(cfg_tap_high_q) * ABS_W'(RING_DEPTH);
	assign band = (dev_q > low_lim) && (dev_q < high_lim);

	always_comb begin
		dec_armed = armed_q;
		dec_countdown = countdown_q;
		dec_gap = gap_q;
		dec_total = total_q;
		dec_detected = 1'b0;
		dec_ticks = ticks_q;
		if (stable_q && band) begin
			if (!armed_q) begin
				dec_countdown = 1'b1;
				dec_gap = dev_q;
				dec_armed = 1'b1;
			end else if (dev_q < gap_q) begin
				dec_gap = dev_q;
			end else begin
				// second spike completes the double tap
				dec_total = total_q + 1'b1;
				dec_detected = 1'b1;
				dec_armed = 1'b0;
			end
		end
		if (ticks_q > adtd_pkg::TICKS_W'(cfg_window_q)) begin
			dec_armed = 1'b0;
			dec_ticks = '0;
			dec_countdown = 1'b0;
			dec_gap = '0;
		end
	end

	// cell row control
	always_comb begin
		ctl.shift = (state_q == ST_SUM);
		ctl.load_xyz = in_fire && !warm;
		ctl.load_base = (in_fire && warm) || ((state_q == ST_DECIDE) && stable_q && !band);
		ctl.copy_base = (state_q == ST_DECIDE) && stable_q;
	end

	assign wr_z = (state_q == ST_IDLE) ? in_z : z_q;

	for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
		adtd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (wp_q == PTR_W'(k)),
			.next_entry (entries[(k + 1) % RING_DEPTH]),
			.wr_x       (in_x),
			.wr_y       (in_y),
			.wr_z       (wr_z),
			.entry      (entries[k])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_warmup_q <= adtd_pkg::WARMUP_RESET;
			cfg_stable_q <= adtd_pkg::STABLE_RESET;
			cfg_tap_low_q <= adtd_pkg::TAP_LOW_RESET;
			cfg_tap_high_q <= adtd_pkg::TAP_HIGH_RESET;
			cfg_window_q <= adtd_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (adtd_pkg::cfg_index_t'(cfg_index))
				adtd_pkg::CFG_WARMUP: cfg_warmup_q <= cfg_data[adtd_pkg::WARMUP_W-1:0];
				adtd_pkg::CFG_STABLE: cfg_stable_q <= cfg_data[adtd_pkg::STABLE_W-1:0];
				adtd_pkg::CFG_TAP_LOW: cfg_tap_low_q <= cfg_data[adtd_pkg::TAP_W-1:0];
				adtd_pkg::CFG_TAP_HIGH: cfg_tap_high_q <= cfg_data[adtd_pkg::TAP_W-1:0];
				adtd_pkg::CFG_WINDOW: cfg_window_q <= cfg_data[adtd_pkg::WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q <= '0;
			cnt_q <= '0;
			warm_cnt_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			gap_q <= '0;
			armed_q <= 1'b0;
			countdown_q <= 1'b0;
			detected_q <= 1'b0;
			stable_q <= 1'b0;
			ticks_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (countdown_q && (ticks_q != adtd_pkg::TICKS_MAX)) begin
							ticks_q <= ticks_q + 1'b1;
						end
						wp_q <= next_pos(wp_q);
						if (warm) begin
							warm_cnt_q <= warm_cnt_q + 1'b1;
							detected_q <= 1'b0;
							stable_q <= 1'b0;
							state_q <= ST_HOLD;
						end else begin
							cnt_q <= '0;
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (cnt_q == LAST_POS) begin
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CHECK: begin
					stable_q <= stable_now;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (stable_q && !band) begin
						wp_q <= next_pos(wp_q);
					end
					armed_q <= dec_armed;
					countdown_q <= dec_countdown;
					gap_q <= dec_gap;
					total_q <= dec_total;
					detected_q <= dec_detected;
					ticks_q <= dec_ticks;
					prev_x_q <= acc_x_q;
					prev_y_q <= acc_y_q;
					prev_z_q <= acc_z_q;
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window sums, sample and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			z_q <= in_z;
			acc_b_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end
		if (state_q == ST_SUM) begin
			acc_b_q <= acc_b_q + SUM_W'($signed(entries[0].base));
			acc_x_q <= acc_x_q + SUM_W'($signed(entries[0].x));
			acc_y_q <= acc_y_q + SUM_W'($signed(entries[0].y));
			acc_z_q <= acc_z_q + SUM_W'($signed(entries[0].z));
		end
		if (state_q == ST_CHECK) begin
			dev_q <= dev;
		end
		if (out_load) begin
			out_data_q <= {5'd0, armed_q, stable_q, detected_q, total_q};
		end
	end

endmodule

FILE: rtl/adtd_cell.sv
module adtd_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  adtd_pkg::cell_ctl_t               ctl,
	input  logic                              sel,
	input  adtd_pkg::ring_entry_t             next_entry,
	input  logic [adtd_pkg::ACCEL_W-1:0]      wr_x,
	input  logic [adtd_pkg::ACCEL_W-1:0]      wr_y,
	input  logic [adtd_pkg::ACCEL_W-1:0]      wr_z,
	output adtd_pkg::ring_entry_t             entry
);

	adtd_pkg::ring_entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.base <= adtd_pkg::ENTRY_RESET;
			entry_q.x <= adtd_pkg::ENTRY_RESET;
			entry_q.y <= adtd_pkg::ENTRY_RESET;
			entry_q.z <= adtd_pkg::ENTRY_RESET;
		end else if (ctl.shift) begin
			// rotate one slot toward the head of the row
			entry_q <= next_entry;
		end else begin
			// single write wins over the copy
			if (ctl.load_base && sel) begin
				entry_q.base <= wr_z;
			end else if (ctl.copy_base) begin
				entry_q.base <= entry_q.z;
			end
			if (ctl.load_xyz && sel) begin
				entry_q.x <= wr_x;
				entry_q.y <= wr_y;
				entry_q.z <= wr_z;
			end
		end
	end

	assign entry = entry_q;

endmodule

FILE: rtl/adtd_checker.sv
`include "accel_double_tap_detector_unit_defines.svh"

module adtd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [adtd_pkg::M_TDATA_W-1:0]     m_tdata
);

	// a finished double tap always comes from a stable sample
	`ADTD_ASSERT_SAME(a_tap_needs_stable, m_tvalid && m_tdata[16], m_tdata[17], "tap without stable board")

	// a finished double tap leaves the detector disarmed
	`ADTD_ASSERT_SAME(a_tap_disarms, m_tvalid && m_tdata[16], !m_tdata[18], "armed after double tap")

	// one sample at a time: no second transfer right after one
	`ADTD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "ready right after a transfer")

	// a stalled result is not dropped
	`ADTD_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind accel_double_tap_detector_unit adtd_checker u_adtd_checker (.*);
